// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define TLI_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tli assertion failed");

// expression must never be true outside reset
`define TLI_ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("tli forbidden condition seen");

`endif

// ----- rtl/core/tli_pkg.sv -----
package tli_pkg;

  // port and register widths
  localparam int unsigned RADIUS_W  = 31;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W   = 5;

  // datapath widths
  localparam int unsigned MUL_W    = 64;
  localparam int unsigned MUL_HALF = 32;
  localparam int unsigned PROD_W   = 128;
  localparam int unsigned SACC_W   = 130;
  localparam int unsigned LIM_W    = 62;
  localparam int unsigned DEN_W    = 62;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_PLANE_OFFSET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NORMAL_X     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NORMAL_Y     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NORMAL_Z     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REF_X        = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REF_Y        = 3'd5;

  // one queued item
  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                first;
  } tli_item_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } tli_unit_st_t;

endpackage

// ----- rtl/core/tli_front.sv -----
`include "assert_macros.svh"

module tli_front import tli_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic                first_i,
  output logic                item_valid_o,
  output tli_item_t           item_o,
  input  logic                pop_i
);

  localparam logic [63:0] RMASK = (64'd1 << (WORD_BITS - 1)) - 64'd1;

  tli_item_t  entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  tli_item_t  in_item;

  // radius bits above the word's magnitude are dropped here
  assign in_item.radius = radius_i & RMASK[RADIUS_W-1:0];
  assign in_item.first  = first_i;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entries_q[rd_ptr_q];

  // two-entry queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      unique case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= in_item;
  end

  `TLI_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop_i |-> (cnt_q != 2'd0))

endmodule

// ----- rtl/core/tli_mul.sv -----
module tli_mul import tli_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_W-1:0]   op_a_i,
  input  logic [MUL_W-1:0]   op_b_i,
  output tli_unit_st_t       st_o,
  output logic [PROD_W-1:0]  prod_o
);

  logic [MUL_W-1:0]    a_q, b_q;
  logic [2:0]          step_q;
  logic                busy_q, done_q;
  logic [MUL_W-1:0]    pp_q;
  logic [1:0]          sh_q;
  logic [PROD_W-1:0]   acc_q, pp_shifted;
  logic [MUL_HALF-1:0] a_half, b_half;

  // one 32x32 partial product per cycle, quarter chosen by step
  assign a_half = step_q[1] ? a_q[MUL_W-1:MUL_HALF] : a_q[MUL_HALF-1:0];
  assign b_half = step_q[0] ? b_q[MUL_W-1:MUL_HALF] : b_q[MUL_HALF-1:0];

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_shifted = {64'd0, pp_q};
      2'd1:    pp_shifted = {32'd0, pp_q, 32'd0};
      2'd2:    pp_shifted = {pp_q, 64'd0};
      default: pp_shifted = '0;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands, partial product register and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= op_a_i;
      b_q   <= op_b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= a_half * b_half;
        sh_q <= 2'(step_q[1]) + 2'(step_q[0]);
      end
      if (step_q != 3'd0) acc_q <= acc_q + pp_shifted;
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign prod_o    = acc_q;

endmodule

// ----- rtl/core/tli_root.sv -----
module tli_root import tli_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] rad_i,
  output tli_unit_st_t      st_o,
  output logic [MUL_W-1:0]  root_o
);

  localparam int unsigned REM_W = MUL_W + 3;

  logic [PROD_W-1:0] d_q;
  logic [REM_W-1:0]  rem_q, rem_sh, trial;
  logic [MUL_W-1:0]  root_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q, ge;

  // restoring square root, two radicand bits per cycle
  assign rem_sh = {rem_q[REM_W-3:0], d_q[PROD_W-1:PROD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(MUL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      d_q    <= {d_q[PROD_W-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[MUL_W-2:0], ge};
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign root_o    = root_q;

endmodule

// ----- rtl/core/tli_div.sv -----
module tli_div import tli_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [PROD_W-1:0]    num_i,
  input  logic [DEN_W-1:0]     den_i,
  output tli_unit_st_t         st_o,
  output logic                 ovf_o,
  output logic [WORD_BITS-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(WORD_BITS);

  logic [PROD_W-1:0]    num_hi;
  logic                 start_ovf;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic [DEN_W:0]       rem_sh;
  logic [WORD_BITS-1:0] lo_q, quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q, ovf_q, ge;

  // quotient reaches 2^WORD_BITS exactly when the upper part is not below the divisor
  assign num_hi    = num_i >> WORD_BITS;
  assign start_ovf = (num_hi >= PROD_W'(den_i));

  // one quotient bit per cycle
  assign rem_sh = {rem_q, lo_q[WORD_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  // fixed run length so that both dividers finish together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WORD_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= start_ovf;
      den_q <= den_i;
      rem_q <= num_hi[DEN_W-1:0];
      lo_q  <= num_i[WORD_BITS-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      lo_q  <= {lo_q[WORD_BITS-2:0], 1'b0};
      quo_q <= {quo_q[WORD_BITS-2:0], ge};
    end
  end

  assign st_o.busy = busy_q;
  assign st_o.done = done_q;
  assign ovf_o     = ovf_q;
  assign quo_o     = quo_q;

endmodule

// ----- rtl/core/track_layer_intersection_core.sv -----
// Track/layer crossing: for each radius item, the point where the configured track
// circle meets that layer, nearer side chosen on items with first set and reused
// otherwise. A two-item queue takes input while the back end works. A valid item
// takes up to twelve products in the shared 64x64 multiplier unit, one run of the
// square-root unit and one run of the two dividers that run side by side; items found
// invalid early finish sooner. Registers are written and read over the APB port.
`include "assert_macros.svh"

module track_layer_intersection_core import tli_pkg::*; #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [REG_W-1:0]    pwdata,
  output logic [REG_W-1:0]    prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RADIUS_W-1:0] radius_i,
  input  logic                first_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [REG_W-1:0]    point_x_o,
  output logic [REG_W-1:0]    point_y_o,
  output logic                valid_res_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_R2   = 5'd1;
  localparam logic [4:0] S_A    = 5'd2;
  localparam logic [4:0] S_B1   = 5'd3;
  localparam logic [4:0] S_B2   = 5'd4;
  localparam logic [4:0] S_BR   = 5'd5;
  localparam logic [4:0] S_AA   = 5'd6;
  localparam logic [4:0] S_ROOT = 5'd7;
  localparam logic [4:0] S_SIDE = 5'd8;
  localparam logic [4:0] S_C1   = 5'd9;
  localparam logic [4:0] S_C2   = 5'd10;
  localparam logic [4:0] S_N1   = 5'd11;
  localparam logic [4:0] S_N2   = 5'd12;
  localparam logic [4:0] S_N3   = 5'd13;
  localparam logic [4:0] S_N4   = 5'd14;
  localparam logic [4:0] S_DGO  = 5'd15;
  localparam logic [4:0] S_DIV  = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  function automatic logic [MUL_W-1:0] sext(input logic [REG_W-1:0] v);
    logic [MUL_W-1:0]     z;
    logic [WORD_BITS-1:0] w;
    z = MUL_W'(v);
    w = z[WORD_BITS-1:0];
    return {{(MUL_W - WORD_BITS){w[WORD_BITS-1]}}, w};
  endfunction

  function automatic logic [MUL_W-1:0] magn(input logic [MUL_W-1:0] v);
    return v[MUL_W-1] ? (~v + MUL_W'(1)) : v;
  endfunction

  function automatic logic [SACC_W-1:0] term(input logic [PROD_W-1:0] p, input logic neg);
    logic [SACC_W-1:0] z;
    z = SACC_W'(p);
    return neg ? (~z + SACC_W'(1)) : z;
  endfunction

  function automatic logic [PROD_W-1:0] smag(input logic [SACC_W-1:0] v);
    logic [SACC_W-1:0] z;
    z = v[SACC_W-1] ? (~v + SACC_W'(1)) : v;
    return z[PROD_W-1:0];
  endfunction

  // clamp a quotient to the signed word range, ok bit on top
  function automatic logic [REG_W:0] sat(input logic [WORD_BITS-1:0] q, input logic ovf,
                                         input logic neg);
    logic [WORD_BITS-1:0] lim, m, v;
    logic                 ok;
    logic [MUL_W-1:0]     z;
    lim = neg ? (WORD_BITS'(1) << (WORD_BITS - 1))
              : ((WORD_BITS'(1) << (WORD_BITS - 1)) - WORD_BITS'(1));
    ok  = !ovf && (q <= lim);
    m   = ok ? q : lim;
    v   = neg ? (~m + WORD_BITS'(1)) : m;
    z   = MUL_W'(v);
    return {ok, z[REG_W-1:0]};
  endfunction

  logic [REG_W-1:0]     cfg_q [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;

  logic               q_valid, pop;
  tli_item_t          q_item;

  logic               mul_go, root_go, div_go;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;
  tli_unit_st_t       mul_st, root_st, dx_st, dy_st;
  logic [MUL_W-1:0]   root_val;
  logic               dx_ovf, dy_ovf;
  logic [WORD_BITS-1:0] dx_quo, dy_quo;

  logic [4:0]         state_q, state_d;
  logic               valid_q, valid_d, first_q, first_d, side_q, side_d;
  logic               out_valid_q, out_valid_d, out_load;
  logic [LIM_W-1:0]   r2_q, r2_d, b_q, b_d;
  logic [MUL_W-1:0]   a_m_q, a_m_d, s_q, s_d;
  logic               a_n_q, a_n_d;
  logic [SACC_W-1:0]  acc_q, acc_d, nx_q, nx_d;
  logic [REG_W-1:0]   rx_q, rx_d, ry_q, ry_d;
  logic               rv_q, rv_d;
  logic [REG_W-1:0]   px_q, py_q;
  logic               pv_q;

  logic [MUL_W-1:0]   c_s, n1_s, n2_s, n3_s, fx_s, fy_s;
  logic [MUL_W-1:0]   n1_m, n2_m, n3_m, fx_m, fy_m;
  logic               n1_n, n2_n, n3_n, fx_n, fy_n;
  logic [PROD_W-1:0]  p_shr, b_sum, b_shr, d_val;
  logic               p_fit, a_fit, b_fit, aa_ok, cp_pos;
  logic [MUL_W-1:0]   a_sum, a_abs;
  logic [SACC_W-1:0]  cp, ny_sum;
  logic [REG_W:0]     sat_x, sat_y;

  // configuration port
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx < REG_IDX_W'(NUM_REGS)) ? cfg_q[reg_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (psel && penable && pwrite && (reg_idx < REG_IDX_W'(NUM_REGS))) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  // register values as signed words, with magnitude and sign
  assign c_s  = sext(cfg_q[REG_PLANE_OFFSET]);
  assign n1_s = sext(cfg_q[REG_NORMAL_X]);
  assign n2_s = sext(cfg_q[REG_NORMAL_Y]);
  assign n3_s = sext(cfg_q[REG_NORMAL_Z]);
  assign fx_s = sext(cfg_q[REG_REF_X]);
  assign fy_s = sext(cfg_q[REG_REF_Y]);
  assign n1_m = magn(n1_s);
  assign n2_m = magn(n2_s);
  assign n3_m = magn(n3_s);
  assign fx_m = magn(fx_s);
  assign fy_m = magn(fy_s);
  assign n1_n = n1_s[MUL_W-1];
  assign n2_n = n2_s[MUL_W-1];
  assign n3_n = n3_s[MUL_W-1];
  assign fx_n = fx_s[MUL_W-1];
  assign fy_n = fy_s[MUL_W-1];

  // front: input queue
  tli_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .radius_i     (radius_i),
    .first_i      (first_i),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .pop_i        (pop)
  );

  // back: shared multiplier, square root and two dividers
  tli_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .st_o    (mul_st),
    .prod_o  (mul_p)
  );

  tli_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_go),
    .rad_i   (d_val),
    .st_o    (root_st),
    .root_o  (root_val)
  );

  tli_div #(.WORD_BITS(WORD_BITS)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (smag(nx_q)),
    .den_i   (b_q),
    .st_o    (dx_st),
    .ovf_o   (dx_ovf),
    .quo_o   (dx_quo)
  );

  tli_div #(.WORD_BITS(WORD_BITS)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (smag(acc_q)),
    .den_i   (b_q),
    .st_o    (dy_st),
    .ovf_o   (dy_ovf),
    .quo_o   (dy_quo)
  );

  // step arithmetic on the finished product
  assign p_shr  = mul_p >> FRAC_BITS;
  assign p_fit  = (p_shr[PROD_W-1:LIM_W] == '0);
  assign a_sum  = n3_n ? (c_s - p_shr[MUL_W-1:0]) : (c_s + p_shr[MUL_W-1:0]);
  assign a_abs  = magn(a_sum);
  assign a_fit  = (a_abs[MUL_W-1:LIM_W] == '0);
  assign b_sum  = acc_q[PROD_W-1:0] + mul_p;
  assign b_shr  = b_sum >> FRAC_BITS;
  assign b_fit  = (b_shr[PROD_W-1:LIM_W] == '0);
  assign aa_ok  = (acc_q[PROD_W-1:0] >= mul_p);
  assign d_val  = acc_q[PROD_W-1:0] - mul_p;
  assign cp     = acc_q - term(mul_p, fx_n ^ n2_n);
  assign cp_pos = !cp[SACC_W-1] && (cp != '0);
  assign ny_sum = acc_q + term(mul_p, !(n1_n ^ side_q));
  assign sat_x  = sat(dx_quo, dx_ovf, nx_q[SACC_W-1]);
  assign sat_y  = sat(dy_quo, dy_ovf, acc_q[SACC_W-1]);

  // back-end sequencer
  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    first_d  = first_q;
    side_d   = side_q;
    r2_d     = r2_q;
    b_d      = b_q;
    a_m_d    = a_m_q;
    a_n_d    = a_n_q;
    s_d      = s_q;
    acc_d    = acc_q;
    nx_d     = nx_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rv_d     = rv_q;
    mul_go   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    root_go  = 1'b0;
    div_go   = 1'b0;
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          first_d = q_item.first;
          valid_d = 1'b1;
          mul_go  = 1'b1;
          mul_a   = MUL_W'(q_item.radius);
          mul_b   = MUL_W'(q_item.radius);
          state_d = S_R2;
        end
      end
      S_R2: begin
        if (mul_st.done) begin
          if (!p_fit) begin
            valid_d = 1'b0;
            state_d = S_SIDE;
          end else begin
            r2_d    = p_shr[LIM_W-1:0];
            mul_go  = 1'b1;
            mul_a   = n3_m;
            mul_b   = MUL_W'(p_shr[LIM_W-1:0]);
            state_d = S_A;
          end
        end
      end
      S_A: begin
        if (mul_st.done) begin
          if (!p_fit || !a_fit) begin
            valid_d = 1'b0;
            state_d = S_SIDE;
          end else begin
            a_m_d   = a_abs;
            a_n_d   = a_sum[MUL_W-1];
            mul_go  = 1'b1;
            mul_a   = n1_m;
            mul_b   = n1_m;
            state_d = S_B1;
          end
        end
      end
      S_B1: begin
        if (mul_st.done) begin
          acc_d   = SACC_W'(mul_p);
          mul_go  = 1'b1;
          mul_a   = n2_m;
          mul_b   = n2_m;
          state_d = S_B2;
        end
      end
      S_B2: begin
        if (mul_st.done) begin
          if (!b_fit || (b_shr == '0)) begin
            valid_d = 1'b0;
            state_d = S_SIDE;
          end else begin
            b_d     = b_shr[LIM_W-1:0];
            mul_go  = 1'b1;
            mul_a   = MUL_W'(b_shr[LIM_W-1:0]);
            mul_b   = MUL_W'(r2_q);
            state_d = S_BR;
          end
        end
      end
      S_BR: begin
        if (mul_st.done) begin
          acc_d   = SACC_W'(mul_p);
          mul_go  = 1'b1;
          mul_a   = a_m_q;
          mul_b   = a_m_q;
          state_d = S_AA;
        end
      end
      S_AA: begin
        if (mul_st.done) begin
          if (!aa_ok) begin
            valid_d = 1'b0;
            state_d = S_SIDE;
          end else begin
            root_go = 1'b1;
            state_d = S_ROOT;
          end
        end
      end
      S_ROOT: begin
        if (root_st.done) begin
          s_d     = root_val;
          state_d = S_SIDE;
        end
      end
      S_SIDE: begin
        if (!valid_q) begin
          if (first_q) side_d = 1'b0;
          rx_d    = '0;
          ry_d    = '0;
          rv_d    = 1'b0;
          state_d = S_OUT;
        end else if (first_q && (s_q != '0)) begin
          mul_go  = 1'b1;
          mul_a   = fy_m;
          mul_b   = n1_m;
          state_d = S_C1;
        end else begin
          if (first_q) side_d = 1'b0;
          mul_go  = 1'b1;
          mul_a   = n1_m;
          mul_b   = a_m_q;
          state_d = S_N1;
        end
      end
      S_C1: begin
        if (mul_st.done) begin
          acc_d   = term(mul_p, fy_n ^ n1_n);
          mul_go  = 1'b1;
          mul_a   = fx_m;
          mul_b   = n2_m;
          state_d = S_C2;
        end
      end
      S_C2: begin
        if (mul_st.done) begin
          // minus side when the reference lies strictly on its side
          side_d  = cp_pos;
          mul_go  = 1'b1;
          mul_a   = n1_m;
          mul_b   = a_m_q;
          state_d = S_N1;
        end
      end
      S_N1: begin
        if (mul_st.done) begin
          nx_d    = term(mul_p, !(n1_n ^ a_n_q));
          mul_go  = 1'b1;
          mul_a   = n2_m;
          mul_b   = s_q;
          state_d = S_N2;
        end
      end
      S_N2: begin
        if (mul_st.done) begin
          nx_d    = nx_q + term(mul_p, n2_n ^ side_q);
          mul_go  = 1'b1;
          mul_a   = n2_m;
          mul_b   = a_m_q;
          state_d = S_N3;
        end
      end
      S_N3: begin
        if (mul_st.done) begin
          acc_d   = term(mul_p, !(n2_n ^ a_n_q));
          mul_go  = 1'b1;
          mul_a   = n1_m;
          mul_b   = s_q;
          state_d = S_N4;
        end
      end
      S_N4: begin
        if (mul_st.done) begin
          acc_d   = ny_sum;
          state_d = S_DGO;
        end
      end
      S_DGO: begin
        div_go  = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (dx_st.done) begin
          rx_d    = sat_x[REG_W-1:0];
          ry_d    = sat_y[REG_W-1:0];
          rv_d    = sat_x[REG_W] && sat_y[REG_W];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= 1'b0;
      first_q     <= 1'b0;
      side_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      first_q     <= first_d;
      side_q      <= side_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and output registers
  always_ff @(posedge clk_i) begin
    r2_q  <= r2_d;
    b_q   <= b_d;
    a_m_q <= a_m_d;
    a_n_q <= a_n_d;
    s_q   <= s_d;
    acc_q <= acc_d;
    nx_q  <= nx_d;
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    rv_q  <= rv_d;
    if (out_load) begin
      px_q <= rx_q;
      py_q <= ry_q;
      pv_q <= rv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign valid_res_o = pv_q;

  `TLI_ASSERT(a_mul_free, clk_i, rst_ni, mul_go |-> !mul_st.busy)
  `TLI_ASSERT(a_div_lockstep, clk_i, rst_ni, dx_st.done == dy_st.done)
  `TLI_ASSERT_NEVER(a_idle_busy, clk_i, rst_ni, (state_q == S_IDLE) && (mul_st.busy || root_st.busy))

endmodule
